[hdl/xor_plane_span_extractor_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the span extractor
// Shared property shapes for the checker.
// ----------------------------------------------------------------------------
`ifndef XOR_PLANE_SPAN_EXTRACTOR_UNIT_DEFINES_SVH
`define XOR_PLANE_SPAN_EXTRACTOR_UNIT_DEFINES_SVH

// same-cycle implication
`define XPSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define XPSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/xpse_pkg.sv]
// ----------------------------------------------------------------------------
// Span extractor package
// Configuration, span record and queue types shared by the block.
// ----------------------------------------------------------------------------
package xpse_pkg;

	localparam int BYTE_BITS = 8;
	localparam int MAX_BPR   = 512;
	localparam int MAX_ROWS  = 4096;
	localparam int SPANS_MAX = 4;
	localparam int Q_DEPTH   = 4;
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);

	localparam logic [2:0] CFG_PIXEL_WIDTH   = 3'd0;
	localparam logic [2:0] CFG_BYTES_PER_ROW = 3'd1;
	localparam logic [2:0] CFG_ROW_COUNT     = 3'd2;
	localparam logic [2:0] CFG_X_ORIGIN      = 3'd3;
	localparam logic [2:0] CFG_Y_ORIGIN      = 3'd4;

	typedef struct packed {
		logic [12:0] pixel_width;
		logic [9:0]  bytes_per_row;
		logic [12:0] row_count;
		logic [15:0] x_origin;
		logic [15:0] y_origin;
	} cfg_t;

	typedef struct packed {
		logic [15:0] first_x;
		logic [15:0] last_x;
	} span_t;

	typedef struct packed {
		logic [15:0]              row;
		logic [2:0]               count;
		span_t [SPANS_MAX-1:0]    spans;
	} rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

[hdl/xpse_ifs.sv]
// ----------------------------------------------------------------------------
// Span extractor channels
// Byte input channel and span output channel with valid/ready.
// ----------------------------------------------------------------------------
interface xpse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] plane_byte;
	logic       image_start;

	modport source (output valid, output plane_byte, output image_start, input ready);
	modport sink (input valid, input plane_byte, input image_start, output ready);
endinterface

interface xpse_out_if;
	logic              valid;
	logic              ready;
	logic signed [15:0] span_row;
	logic signed [15:0] span_first_x;
	logic signed [15:0] span_last_x;
	logic              last_of_byte;

	modport source (output valid, output span_row, output span_first_x,
		output span_last_x, output last_of_byte, input ready);
	modport sink (input valid, input span_row, input span_first_x,
		input span_last_x, input last_of_byte, output ready);
endinterface

[hdl/xpse_front.sv]
// ----------------------------------------------------------------------------
// Span extractor front end
// Accepts plane bytes, pairs edge bits and pushes one span record per byte that closes a span.
// ----------------------------------------------------------------------------
module xpse_front import xpse_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	xpse_in_if.sink   in_ch,
	input  cfg_t      cfg,
	input  q_stat_t   q_stat,
	output logic      push,
	output rec_t      push_rec
);

	logic [8:0]  col_q, col, nxt_col;
	logic [11:0] row_q, row, nxt_row;
	logic        ins_q, ins, nxt_ins;
	logic [15:0] beg_q, beg;
	logic        done_q, done, nxt_done;
	logic [9:0]  bpr;
	logic [12:0] wlim, width, rows, p;
	logic [11:0] pbase;
	logic [15:0] xbase;
	logic [2:0]  n;
	rec_t        rec;
	logic        accept;

	assign in_ch.ready = !q_stat.full;
	assign accept      = in_ch.valid && in_ch.ready;

	always_comb begin
		col  = in_ch.image_start ? '0 : col_q;
		row  = in_ch.image_start ? '0 : row_q;
		ins  = in_ch.image_start ? 1'b0 : ins_q;
		done = in_ch.image_start ? 1'b0 : done_q;

		bpr = cfg.bytes_per_row;
		if (bpr == '0) begin
			bpr = 10'd1;
		end else if (bpr > 10'(MAX_BPR)) begin
			bpr = 10'(MAX_BPR);
		end
		wlim  = {bpr, 3'b000};
		width = (cfg.pixel_width > wlim) ? wlim : cfg.pixel_width;
		rows  = (cfg.row_count > 13'(MAX_ROWS)) ? 13'(MAX_ROWS) : cfg.row_count;

		pbase = {col, 3'b000};
		xbase = cfg.x_origin + {4'b0000, pbase};
		beg   = beg_q;
		n     = '0;
		p     = '0;
		rec   = '0;
		for (int i = 0; i < BYTE_BITS; i++) begin
			p = {1'b0, pbase} + 13'(i);
			if (p < width && in_ch.plane_byte[BYTE_BITS-1-i]) begin
				if (!ins) begin
					if (p + 13'd1 < width) begin
						ins = 1'b1;
						beg = xbase + 16'(i + 1);
					end
				end else begin
					rec.spans[n[1:0]].first_x = beg;
					rec.spans[n[1:0]].last_x  = xbase + 16'(i);
					n   = n + 3'd1;
					ins = 1'b0;
				end
			end
		end
		rec.count = n;
		rec.row   = cfg.y_origin + {4'b0000, row};

		nxt_done = done;
		nxt_row  = row;
		if ({1'b0, col} + 10'd1 >= bpr) begin
			nxt_col = '0;
			nxt_ins = 1'b0;
			if ({1'b0, row} + 13'd1 >= rows) begin
				nxt_done = 1'b1;
			end else begin
				nxt_row = row + 12'd1;
			end
		end else begin
			nxt_col = col + 9'd1;
			nxt_ins = ins;
		end
	end

	assign push     = accept && !done && (n != '0);
	assign push_rec = rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			ins_q  <= 1'b0;
			beg_q  <= '0;
			done_q <= 1'b1;
		end else if (accept && !done) begin
			col_q  <= nxt_col;
			row_q  <= nxt_row;
			ins_q  <= nxt_ins;
			beg_q  <= beg;
			done_q <= nxt_done;
		end else if (accept) begin
			done_q <= done;
		end
	end

endmodule

[hdl/xpse_queue.sv]
// ----------------------------------------------------------------------------
// Span record queue
// Short FIFO of span records between front end and back end.
// ----------------------------------------------------------------------------
module xpse_queue import xpse_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  rec_t    push_rec,
	input  logic    pop,
	output rec_t    head,
	output q_stat_t q_stat
);

	rec_t               mem [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q, rd_q;
	logic [Q_PTR_W:0]   cnt_q;

	assign head         = mem[rd_q];
	assign q_stat.full  = (cnt_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign q_stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[hdl/xpse_back.sv]
// ----------------------------------------------------------------------------
// Span extractor back end
// Walks the head record and sends one span per beat through an output register.
// ----------------------------------------------------------------------------
module xpse_back import xpse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  rec_t       head,
	input  q_stat_t    q_stat,
	output logic       pop,
	xpse_out_if.source out_ch
);

	logic [1:0]  idx_q;
	logic        vld_q;
	logic [15:0] row_q, first_q, last_q;
	logic        lob_q;
	logic        load, last;

	assign load = !q_stat.empty && (!vld_q || out_ch.ready);
	assign last = ({1'b0, idx_q} + 3'd1 == head.count);
	assign pop  = load && last;

	assign out_ch.valid        = vld_q;
	assign out_ch.span_row     = row_q;
	assign out_ch.span_first_x = first_q;
	assign out_ch.span_last_x  = last_q;
	assign out_ch.last_of_byte = lob_q;

	always_ff @(posedge clk) begin
		if (load) begin
			row_q   <= head.row;
			first_q <= head.spans[idx_q].first_x;
			last_q  <= head.spans[idx_q].last_x;
			lob_q   <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			vld_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= last ? '0 : idx_q + 2'd1;
				vld_q <= 1'b1;
			end else if (out_ch.ready) begin
				vld_q <= 1'b0;
			end
		end
	end

endmodule

[hdl/xor_plane_span_extractor_unit.sv]
// Throughput: one byte per cycle while the record queue is not full; a byte that closes
// k spans sends them as k output beats, and a four-record queue absorbs bursts while
// the output register drains.
// Reset: asynchronous, active low; the unit waits for image_start, config returns
// to width 8, one byte per row, one row, origin zero.
// ----------------------------------------------------------------------------
// Edge bit-plane span extractor, top level
// Configuration registers, front end, record queue and back end.
// ----------------------------------------------------------------------------
module xor_plane_span_extractor_unit import xpse_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	xpse_in_if.sink     in_ch,
	xpse_out_if.source  out_ch
);

	cfg_t    cfg_q;
	q_stat_t q_stat;
	logic    push, pop;
	rec_t    push_rec, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_width   <= 13'd8;
			cfg_q.bytes_per_row <= 10'd1;
			cfg_q.row_count     <= 13'd1;
			cfg_q.x_origin      <= '0;
			cfg_q.y_origin      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PIXEL_WIDTH:   cfg_q.pixel_width   <= cfg_data[12:0];
				CFG_BYTES_PER_ROW: cfg_q.bytes_per_row <= cfg_data[9:0];
				CFG_ROW_COUNT:     cfg_q.row_count     <= cfg_data[12:0];
				CFG_X_ORIGIN:      cfg_q.x_origin      <= cfg_data;
				CFG_Y_ORIGIN:      cfg_q.y_origin      <= cfg_data;
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	xpse_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.cfg      (cfg_q),
		.q_stat   (q_stat),
		.push     (push),
		.push_rec (push_rec)
	);

	xpse_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	xpse_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule

[hdl/xpse_checker.sv]
// ----------------------------------------------------------------------------
// Span extractor port checker
// Watches the top-level ports for output stalls, span shape and beat order.
// ----------------------------------------------------------------------------
`include "xor_plane_span_extractor_unit_defines.svh"

module xpse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] span_row,
	input logic [15:0] span_first_x,
	input logic [15:0] span_last_x,
	input logic        last_of_byte
);

	logic [15:0] span_len;

	assign span_len = span_last_x - span_first_x;

	`XPSE_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(span_row) && $stable(span_first_x) && $stable(span_last_x) && $stable(last_of_byte), "span beat changed while stalled")
	`XPSE_ASSERT_IMP(a_full_has_out, clk, arst_n, !in_ready, out_valid, "input held off with no span waiting")
	`XPSE_ASSERT_IMP(a_span_len, clk, arst_n, out_valid, span_len[15:12] == 4'd0, "span longer than a row")
	`XPSE_ASSERT_NXT(a_byte_cont, clk, arst_n, out_valid && out_ready && !last_of_byte, out_valid && (span_row == $past(span_row)), "byte's spans broken apart")

endmodule

bind xor_plane_span_extractor_unit xpse_checker u_xpse_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.span_row     (out_ch.span_row),
	.span_first_x (out_ch.span_first_x),
	.span_last_x  (out_ch.span_last_x),
	.last_of_byte (out_ch.last_of_byte)
);

[tb/xpse_span_checker.sv]
// ----------------------------------------------------------------------------
// Span extractor checker
// Watches the configuration port and both channels, predicts the spans of
// every accepted plane byte and compares each span beat field by field.
// ----------------------------------------------------------------------------
module xpse_span_checker import xpse_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	xpse_in_if          in_ch,
	xpse_out_if         out_ch,
	output int          pending,
	output int          fail_count,
	output int          span_beats
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [15:0] row;
		logic [15:0] first_x;
		logic [15:0] last_x;
		logic        last_of_byte;
	} span_beat_t;

	span_beat_t  span_q[$];

	logic [12:0] pix_w;
	logic [9:0]  bpr;
	logic [12:0] rows;
	logic [15:0] x_org;
	logic [15:0] y_org;

	logic [8:0]  col;
	logic [11:0] row_idx;
	logic        in_span;
	logic [15:0] span_begin;
	logic        img_done;

	function automatic void extract_spans(input logic [7:0] plane, input logic start);
		int unsigned bpr_eff;
		int unsigned width_eff;
		int unsigned rows_eff;
		int unsigned pix;
		int          first;
		logic [15:0] row_y;
		span_beat_t  beat;
		if (start) begin
			col      = '0;
			row_idx  = '0;
			in_span  = 1'b0;
			img_done = 1'b0;
		end
		if (img_done)
			return;
		bpr_eff   = (bpr == 0) ? 1 : ((bpr > MAX_BPR) ? MAX_BPR : bpr);
		width_eff = (pix_w > 8 * bpr_eff) ? 8 * bpr_eff : pix_w;
		rows_eff  = (rows > MAX_ROWS) ? MAX_ROWS : rows;
		row_y     = y_org + 16'(row_idx);
		first     = span_q.size();
		for (int i = 0; i < 8; i++) begin
			pix = col * 8 + i;
			if (pix >= width_eff)
				break;
			if (!plane[7 - i])
				continue;
			if (!in_span) begin
				if (pix + 1 < width_eff) begin
					in_span    = 1'b1;
					span_begin = x_org + 16'(pix + 1);
				end
			end else begin
				beat.row          = row_y;
				beat.first_x      = span_begin;
				beat.last_x       = 16'(x_org + pix);
				beat.last_of_byte = 1'b0;
				span_q.push_back(beat);
				in_span = 1'b0;
			end
		end
		if (span_q.size() > first)
			span_q[span_q.size() - 1].last_of_byte = 1'b1;
		// close the row, then the image
		if (col + 1 >= bpr_eff) begin
			col     = '0;
			in_span = 1'b0;
			if (row_idx + 1 >= rows_eff)
				img_done = 1'b1;
			else
				row_idx = row_idx + 12'd1;
		end else begin
			col = col + 9'd1;
		end
	endfunction

	task automatic compare_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		span_beat_t want;
		if (!arst_n) begin
			pix_w      = 13'd8;
			bpr        = 10'd1;
			rows       = 13'd1;
			x_org      = '0;
			y_org      = '0;
			col        = '0;
			row_idx    = '0;
			in_span    = 1'b0;
			span_begin = '0;
			img_done   = 1'b1;
			span_q.delete();
			fail_count = 0;
			span_beats = 0;
			pending   <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PIXEL_WIDTH:   pix_w = cfg_data[12:0];
					CFG_BYTES_PER_ROW: bpr   = cfg_data[9:0];
					CFG_ROW_COUNT:     rows  = cfg_data[12:0];
					CFG_X_ORIGIN:      x_org = cfg_data;
					CFG_Y_ORIGIN:      y_org = cfg_data;
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				extract_spans(in_ch.plane_byte, in_ch.image_start);
			if (out_ch.valid && out_ch.ready) begin
				span_beats++;
				if (span_q.size() == 0) begin
					$error("span beat with none expected: row %0d, x %0d..%0d",
						out_ch.span_row, out_ch.span_first_x, out_ch.span_last_x);
					fail_count++;
				end else begin
					want = span_q.pop_front();
					compare_field("span_row", want.row, out_ch.span_row);
					compare_field("span_first_x", want.first_x, out_ch.span_first_x);
					compare_field("span_last_x", want.last_x, out_ch.span_last_x);
					compare_field("last_of_byte", 16'(want.last_of_byte),
						16'(out_ch.last_of_byte));
				end
			end
			pending <= span_q.size();
		end
	end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Span extractor testbench
// Feeds edge bit-planes through directed and random images under several
// configurations and idle mixes; the checker predicts and compares spans.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import xpse_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_BYTES  = 360;
	localparam int WIDE_BYTES    = 48;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	xpse_in_if  in_ch();
	xpse_out_if out_ch();

	int pending;
	int fail_count;
	int span_beats;
	int cycles = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_reqs = 0;
	int hold_seen;
	int hold_left;
	int plane_bytes = 0;
	int random_bytes = 0;
	int images = 0;

	xor_plane_span_extractor_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	xpse_span_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.pending    (pending),
		.fail_count (fail_count),
		.span_beats (span_beats)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// span receiver: random stalls, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_seen    <= 0;
			hold_left    <= 0;
		end else if (hold_reqs != hold_seen) begin
			hold_seen    <= hold_reqs;
			hold_left    <= HOLD_CYCLES;
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left    <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic set_config(input logic [15:0] pw, input logic [15:0] bpr,
		input logic [15:0] rc, input logic [15:0] xo, input logic [15:0] yo);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_PIXEL_WIDTH;
		cfg_data  <= pw;
		@(posedge clk);
		cfg_index <= CFG_BYTES_PER_ROW;
		cfg_data  <= bpr;
		@(posedge clk);
		cfg_index <= CFG_ROW_COUNT;
		cfg_data  <= rc;
		@(posedge clk);
		cfg_index <= CFG_X_ORIGIN;
		cfg_data  <= xo;
		@(posedge clk);
		cfg_index <= CFG_Y_ORIGIN;
		cfg_data  <= yo;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_byte(input logic [7:0] plane, input logic start);
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.plane_byte  <= plane;
		in_ch.image_start <= start;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		plane_bytes++;
		if (start)
			images++;
	endtask

	function automatic logic [7:0] rand_plane_byte();
		case ($urandom_range(9))
			0, 1:    return 8'h00;
			2:       return 8'h80 >> $urandom_range(7);
			3:       return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(4))
			0:       return 16'h7FF0 + 16'($urandom_range(15));
			1:       return 16'h8000 + 16'($urandom_range(15));
			2:       return 16'hFFF0 + 16'($urandom_range(15));
			default: return 16'($urandom_range(16'hFFFF));
		endcase
	endfunction

	task automatic run_image();
		int unsigned pw;
		int unsigned bpr;
		int unsigned rc;
		int unsigned bpr_eff;
		int unsigned rows_eff;
		int unsigned total;
		int unsigned n_send;
		int unsigned change_at;
		logic [15:0] xo;
		logic [15:0] yo;
		case ($urandom_range(9))
			0:       pw = $urandom_range(8191);
			1:       pw = $urandom_range(1);
			default: pw = $urandom_range(1, 40);
		endcase
		case ($urandom_range(9))
			0:       bpr = $urandom_range(1023);
			1:       bpr = 0;
			default: bpr = $urandom_range(1, 5);
		endcase
		case ($urandom_range(9))
			0:       rc = $urandom_range(8191);
			1:       rc = 0;
			default: rc = $urandom_range(1, 5);
		endcase
		xo = rand_coord();
		yo = rand_coord();
		wait_idle();
		set_config(16'(pw), 16'(bpr), 16'(rc), xo, yo);
		bpr_eff  = (bpr == 0) ? 1 : ((bpr > MAX_BPR) ? MAX_BPR : bpr);
		rows_eff = (rc == 0) ? 1 : ((rc > MAX_ROWS) ? MAX_ROWS : rc);
		total    = bpr_eff * rows_eff;
		n_send   = (total > 48) ? $urandom_range(1, 48) : total;
		if ($urandom_range(4) == 0)
			n_send = $urandom_range(1, n_send);
		change_at = ($urandom_range(9) == 0) ? $urandom_range(n_send - 1) : n_send;
		for (int unsigned k = 0; k < n_send; k++) begin
			if (k == change_at && k > 0) begin
				wait_idle();
				set_config(16'($urandom_range(1, 40)), 16'($urandom_range(1, 5)),
					16'(rc), xo, yo);
			end
			send_byte(rand_plane_byte(), k == 0);
			random_bytes++;
		end
		// trailing bytes without a start: ignored if the image is already done
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 3)) send_byte(rand_plane_byte(), 1'b0);
	endtask

	initial begin
		in_ch.valid       = 1'b0;
		in_ch.plane_byte  = '0;
		in_ch.image_start = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = CFG_PIXEL_WIDTH;
		cfg_data          = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: idle drop, full byte, wide pair, start on last pixel
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h81, 1'b1);
		send_byte(8'h01, 1'b1);

		// span across bytes, padding, unpaired start dropped, coordinate wrap
		wait_idle();
		set_config(16'd13, 16'd2, 16'd3, 16'h7FFE, 16'h7FFF);
		send_byte(8'h80, 1'b1);
		send_byte(8'h08, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h0C, 1'b0);
		send_byte(8'h40, 1'b0);
		send_byte(8'hFF, 1'b0);

		// zero bytes per row and zero rows; row narrower than pixel width
		wait_idle();
		set_config(16'd16, 16'd0, 16'd0, 16'h8000, 16'h8000);
		send_byte(8'hC3, 1'b1);
		send_byte(8'hFF, 1'b0);

		// zero width, then one pixel per row
		wait_idle();
		set_config(16'd0, 16'd1, 16'd4096, 16'hFFFF, 16'hFFFF);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h55, 1'b0);
		wait_idle();
		set_config(16'd1, 16'd1, 16'd2, 16'h0000, 16'h7FFF);
		send_byte(8'h80, 1'b1);
		send_byte(8'hC0, 1'b0);

		// fill the span queue behind a long receiver hold-off
		wait_idle();
		set_config(16'd64, 16'd8, 16'd4, 16'h0100, 16'hFF00);
		hold_reqs++;
		for (int i = 0; i < 32; i++)
			send_byte(8'hFF, i == 0);
		wait_idle();

		// wide row: bytes per row above the limit, x wrapping past the top
		set_config(16'd8191, 16'd700, 16'd1, 16'h7F80, 16'h1234);
		for (int i = 0; i < WIDE_BYTES; i++)
			send_byte(rand_plane_byte(), i == 0);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 61;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 61;
				end
				default: begin
					idle_pct  = 18;
					stall_pct = 18;
				end
			endcase
			while (random_bytes < (ph + 1) * RANDOM_BYTES / 4)
				run_image();
		end

		wait_idle();
		repeat (20) @(posedge clk);
		$display("Covered %0d plane bytes in %0d images, %0d spans checked,", plane_bytes,
			images, span_beats);
		$display("four idle mixes and one long output hold-off.");
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[sim.f]
+incdir+hdl
hdl/xpse_pkg.sv
hdl/xpse_ifs.sv
hdl/xpse_front.sv
hdl/xpse_queue.sv
hdl/xpse_back.sv
hdl/xor_plane_span_extractor_unit.sv
hdl/xpse_checker.sv
tb/xpse_span_checker.sv
tb/tb.sv
